### hdl/cse_pkg.sv
`timescale 1ns / 1ps

package cse_pkg;

	// store geometry
	localparam int DEPTH   = 1024;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	// gap shrink: floor(gap*10/13) by reciprocal multiply
	localparam int GAP10_W   = CNT_W + 4;
	localparam int DIV_SHIFT = GAP10_W + 4;
	localparam int MUL_W     = DIV_SHIFT - 3;
	localparam int PROD_W    = GAP10_W + MUL_W;
	localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'((64'd1 << DIV_SHIFT) / 13 + 1);

	// item codes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_READ = 1'b1;

endpackage

### hdl/comb_sort_engine.sv
`timescale 1ns / 1ps

// Load words one per cycle (mode 0) while busy is low; the word with last set starts an
// in-place comb sort into ascending signed order; read words (mode 1) then return the
// sorted values one per cycle, each result strobed on done for one cycle, the cycle
// after the read is taken, with last_res on the final value and empty_res once nothing
// is left (or before a sort). After the last load busy stays high for the sort, whose
// passes make N - gap compares each; a swap adds a write of the high element, as the
// element RAM has a single write port. Results cannot be stalled; there is no clearing
// pass after reset.
module comb_sort_engine
	import cse_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     mode,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     last,
	output logic                     done,
	output logic signed [DATA_W-1:0] value_res,
	output logic                     last_res,
	output logic                     empty_res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_GAP,
		S_RD,
		S_CMP,
		S_WRH,
		S_END
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    rp_q;
	logic [CNT_W-1:0]    gap_q;
	logic [CNT_W-1:0]    idx_q;
	logic                swap_q;
	logic                sorted_q;
	logic [DATA_W-1:0]   x_q;
	logic                fwd_v_q;
	logic [ADDR_W-1:0]   fwd_addr_q;
	logic [DATA_W-1:0]   fwd_data_q;
	logic                done_q;
	logic                last_res_q;
	logic                empty_res_q;
	logic                res_ram_q;

	logic                accept;
	logic [CNT_W-1:0]    count_eff;
	logic                full;
	logic [CNT_W-1:0]    new_count;
	logic                can_read;
	logic [CNT_W-1:0]    base;
	logic [CNT_W:0]      hi_sum;
	logic                more;
	logic [CNT_W:0]      cur_hi;
	logic [GAP10_W-1:0]  gap10;
	logic [PROD_W-1:0]   prod;
	logic [CNT_W-1:0]    quot;
	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [DATA_W-1:0]   wdata;
	logic [ADDR_W-1:0]   raddr_a;
	logic [ADDR_W-1:0]   raddr_b;
	logic [DATA_W-1:0]   rdata_a;
	logic [DATA_W-1:0]   rdata_b;
	logic [DATA_W-1:0]   lo_d;
	logic [DATA_W-1:0]   hi_d;
	logic                do_swap;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// load bookkeeping, a load after a sort opens a new batch
	assign count_eff = sorted_q ? '0 : count_q;
	assign full      = (count_eff == CNT_W'(DEPTH));
	assign new_count = full ? count_eff : CNT_W'(count_eff + 1'b1);
	assign can_read  = sorted_q && (rp_q < count_q);

	// next compare pair of the pass
	assign base   = (state_q == S_RD) ? idx_q : CNT_W'(idx_q + 1'b1);
	assign hi_sum = {1'b0, base} + {1'b0, gap_q};
	assign more   = hi_sum < {1'b0, count_q};
	assign cur_hi = {1'b0, idx_q} + {1'b0, gap_q};

	// gap shrink
	assign gap10 = (GAP10_W'(gap_q) << 3) + (GAP10_W'(gap_q) << 1);
	assign prod  = PROD_W'(gap10) * PROD_W'(DIV_MUL);
	assign quot  = CNT_W'(prod >> DIV_SHIFT);

	// read data with forwarding of the write issued alongside the read
	always_comb begin
		lo_d = rdata_a;
		hi_d = rdata_b;
		if (fwd_v_q && fwd_addr_q == idx_q[ADDR_W-1:0]) begin
			lo_d = fwd_data_q;
		end
		if (fwd_v_q && fwd_addr_q == cur_hi[ADDR_W-1:0]) begin
			hi_d = fwd_data_q;
		end
	end

	assign do_swap = $signed(lo_d) > $signed(hi_d);

	// memory port control
	always_comb begin
		we      = 1'b0;
		waddr   = count_eff[ADDR_W-1:0];
		wdata   = value;
		raddr_a = base[ADDR_W-1:0];
		raddr_b = hi_sum[ADDR_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				we      = accept && (mode == MODE_LOAD) && !full;
				raddr_a = rp_q[ADDR_W-1:0];
			end
			S_CMP: begin
				we    = do_swap;
				waddr = idx_q[ADDR_W-1:0];
				wdata = hi_d;
			end
			S_WRH: begin
				we    = 1'b1;
				waddr = cur_hi[ADDR_W-1:0];
				wdata = x_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	cse_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rp_q        <= '0;
			gap_q       <= '0;
			idx_q       <= '0;
			swap_q      <= 1'b0;
			sorted_q    <= 1'b0;
			x_q         <= '0;
			fwd_v_q     <= 1'b0;
			fwd_addr_q  <= '0;
			fwd_data_q  <= '0;
			done_q      <= 1'b0;
			last_res_q  <= 1'b0;
			empty_res_q <= 1'b0;
			res_ram_q   <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			fwd_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && mode == MODE_LOAD) begin
						count_q  <= new_count;
						sorted_q <= 1'b0;
						rp_q     <= '0;
						swap_q   <= 1'b0;
						if (last) begin
							gap_q   <= new_count;
							state_q <= S_GAP;
						end else begin
							gap_q <= '0;
						end
					end else if (accept) begin
						done_q      <= 1'b1;
						res_ram_q   <= can_read;
						empty_res_q <= !can_read;
						last_res_q  <= can_read && (CNT_W'(rp_q + 1'b1) == count_q);
						if (can_read) begin
							rp_q <= CNT_W'(rp_q + 1'b1);
						end
					end
				end
				S_GAP: begin
					gap_q   <= (quot == '0) ? CNT_W'(1) : quot;
					swap_q  <= 1'b0;
					idx_q   <= '0;
					state_q <= S_RD;
				end
				S_RD: begin
					idx_q   <= base;
					state_q <= more ? S_CMP : S_END;
				end
				S_CMP: begin
					if (do_swap) begin
						x_q     <= lo_d;
						swap_q  <= 1'b1;
						state_q <= S_WRH;
					end else begin
						idx_q   <= base;
						state_q <= more ? S_CMP : S_END;
					end
				end
				S_WRH: begin
					fwd_v_q    <= 1'b1;
					fwd_addr_q <= cur_hi[ADDR_W-1:0];
					fwd_data_q <= x_q;
					idx_q      <= base;
					state_q    <= more ? S_CMP : S_END;
				end
				S_END: begin
					if (gap_q == CNT_W'(1) && !swap_q) begin
						sorted_q <= 1'b1;
						rp_q     <= '0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_GAP;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done      = done_q;
	assign value_res = res_ram_q ? $signed(rdata_a) : '0;
	assign last_res  = last_res_q;
	assign empty_res = empty_res_q;

	// a result always follows an accepted read word
	a_done_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && mode == MODE_READ))
		else $error("result without a read word");

	// a result is never both the final value and empty
	a_res_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(last_res && empty_res))
		else $error("last and empty on one result");

	// the high write of a swap directly follows its compare
	a_swap_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WRH |-> $past(state_q) == S_CMP && $past(do_swap))
		else $error("high write without a swap");

	// compares only run with a valid gap and never on a sorted batch
	a_gap_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP || state_q == S_WRH) |-> gap_q != '0 && !sorted_q)
		else $error("compare with zero gap or sorted flag");

	// reads of the sorted batch stay inside the loaded words
	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sorted_q |-> rp_q <= count_q)
		else $error("read position past the element count");

endmodule

### hdl/cse_ram.sv
`timescale 1ns / 1ps

module cse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### test/cse_sort_checker.sv
`timescale 1ns / 1ps

module cse_sort_checker
	import cse_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic                     mode,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     last,
	input  logic                     done,
	input  logic signed [DATA_W-1:0] value_res,
	input  logic                     last_res,
	input  logic                     empty_res,
	output int                       errors,
	output int                       outstanding,
	output int                       checked,
	output int                       valued
);

	// one predicted read answer
	typedef struct {
		logic signed [DATA_W-1:0] val;
		logic                     fin;
		logic                     emp;
	} read_word_t;

	// predicted engine state
	logic signed [DATA_W-1:0] elems [DEPTH];
	int unsigned              elem_cnt;
	int unsigned              rd_pos;
	bit                       sorted;

	read_word_t sorted_reads_due [$];
	read_word_t due;

	// in-place comb sort of the held elements, gap shrinking by 10/13
	function automatic void comb_sort_elems();
		int unsigned              gap;
		bit                       swapped;
		logic signed [DATA_W-1:0] tmp;
		gap = elem_cnt;
		do begin
			gap = (gap * 10) / 13;
			if (gap < 1)
				gap = 1;
			swapped = 1'b0;
			for (int unsigned i = 0; i + gap < elem_cnt; i++) begin
				if (elems[i] > elems[i + gap]) begin
					tmp            = elems[i];
					elems[i]       = elems[i + gap];
					elems[i + gap] = tmp;
					swapped        = 1'b1;
				end
			end
		end while (gap > 1 || swapped);
	endfunction

	// apply one accepted word to the predicted state
	function automatic void apply_word(input logic m, input logic signed [DATA_W-1:0] v,
		input logic l);
		read_word_t w;
		if (m == MODE_LOAD) begin
			// a load after a finished sort opens a new batch
			if (sorted) begin
				elem_cnt = 0;
				rd_pos   = 0;
				sorted   = 1'b0;
			end
			// loads past a full store are dropped, last still counts
			if (elem_cnt < DEPTH) begin
				elems[elem_cnt] = v;
				elem_cnt++;
			end
			if (l) begin
				comb_sort_elems();
				sorted = 1'b1;
				rd_pos = 0;
			end
		end else begin
			if (sorted && rd_pos < elem_cnt) begin
				w.val = elems[rd_pos];
				w.fin = (rd_pos + 1 == elem_cnt);
				w.emp = 1'b0;
				rd_pos++;
			end else begin
				w.val = '0;
				w.fin = 1'b0;
				w.emp = 1'b1;
			end
			sorted_reads_due.push_back(w);
		end
	endfunction

	// track accepted words and compare each strobed result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_cnt = 0;
			rd_pos   = 0;
			sorted   = 1'b0;
			sorted_reads_due.delete();
			errors  = 0;
			checked = 0;
			valued  = 0;
			outstanding <= 0;
		end else begin
			if (start && !busy)
				apply_word(mode, value, last);
			if ($isunknown(done)) begin
				errors++;
				$display("%0t: done strobe unknown, expected 0 or 1, got %b", $time, done);
			end else if (done) begin
				if (sorted_reads_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got value %0d last %0b empty %0b",
						$time, value_res, last_res, empty_res);
				end else begin
					due = sorted_reads_due.pop_front();
					checked++;
					if (!due.emp)
						valued++;
					if (value_res !== due.val || last_res !== due.fin || empty_res !== due.emp) begin
						errors++;
						$display("%0t: result mismatch, expected value %0d last %0b empty %0b, got value %0d last %0b empty %0b",
							$time, due.val, due.fin, due.emp, value_res, last_res, empty_res);
					end
				end
			end
			outstanding <= sorted_reads_due.size();
		end
	end

endmodule

### test/tb_comb_sort_engine.sv
`timescale 1ns / 1ps

module tb_comb_sort_engine;
	import cse_pkg::*;

	localparam int RAND_WORDS   = 450;
	localparam int OVF_READS    = 96;
	localparam int DRAIN_CYCLES = 20;
	localparam logic signed [DATA_W-1:0] ELEM_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] ELEM_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	logic                     clk    = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start  = 1'b0;
	logic                     mode   = MODE_LOAD;
	logic signed [DATA_W-1:0] value  = '0;
	logic                     last   = 1'b0;
	logic                     busy;
	logic                     done;
	logic signed [DATA_W-1:0] value_res;
	logic                     last_res;
	logic                     empty_res;

	int errors;
	int outstanding;
	int checked;
	int valued;
	int idle_pct  = 0;
	int n_loads   = 0;
	int n_reads   = 0;
	int n_batches = 0;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	comb_sort_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.value     (value),
		.last      (last),
		.done      (done),
		.value_res (value_res),
		.last_res  (last_res),
		.empty_res (empty_res)
	);

	cse_sort_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.value       (value),
		.last        (last),
		.done        (done),
		.value_res   (value_res),
		.last_res    (last_res),
		.empty_res   (empty_res),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.valued      (valued)
	);

	// element values: extremes, dense small values for duplicates, full range
	function automatic logic signed [DATA_W-1:0] rand_elem();
		case ($urandom_range(9))
			0:       return ELEM_MIN;
			1:       return ELEM_MAX;
			2, 3:    return DATA_W'($signed($urandom_range(16)) - 8);
			default: return $urandom;
		endcase
	endfunction

	// offer one word after a random idle gap, hold it until taken
	task automatic send_word(input logic m, input logic signed [DATA_W-1:0] v, input logic l);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			mode  <= 1'($urandom_range(1));
			value <= $urandom;
			last  <= 1'($urandom_range(1));
			@(posedge clk);
		end
		start <= 1'b1;
		mode  <= m;
		value <= v;
		last  <= l;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (m == MODE_LOAD)
			n_loads++;
		else
			n_reads++;
	endtask

	// hold off until every read answer is back
	task automatic drain_pause();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// one batch: loads with stray reads, usually sealed, then reads
	task automatic random_batch();
		int len;
		int nrd;
		case (n_batches % 3)
			0:       idle_pct = 0;
			1:       idle_pct = 47;
			default: idle_pct = 15;
		endcase
		len = ($urandom_range(15) == 0) ? $urandom_range(49, 200) : $urandom_range(1, 48);
		for (int k = 1; k < len; k++) begin
			if ($urandom_range(24) == 0)
				send_word(MODE_READ, $urandom, 1'($urandom_range(1)));
			send_word(MODE_LOAD, rand_elem(), 1'b0);
		end
		// now and then the batch stays open and the reads see empty
		if ($urandom_range(11) != 0) begin
			send_word(MODE_LOAD, rand_elem(), 1'b1);
			n_batches++;
		end
		nrd = ($urandom_range(7) == 0) ? $urandom_range(0, len) : len + $urandom_range(0, 2);
		for (int k = 0; k < nrd; k++)
			send_word(MODE_READ, $urandom, 1'($urandom_range(1)));
		if ($urandom_range(7) == 0)
			drain_pause();
	endtask

	// stimulus
	initial begin
		int rand_base;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty reads, one-element sort, extremes, duplicates
		send_word(MODE_READ, '1, 1'b1);
		send_word(MODE_LOAD, 7, 1'b1);
		send_word(MODE_READ, '0, 1'b0);
		send_word(MODE_READ, '0, 1'b1);
		send_word(MODE_LOAD, ELEM_MIN, 1'b0);
		send_word(MODE_READ, '0, 1'b0);
		send_word(MODE_LOAD, ELEM_MAX, 1'b0);
		send_word(MODE_LOAD, 0, 1'b0);
		send_word(MODE_LOAD, -1, 1'b0);
		send_word(MODE_LOAD, 1, 1'b0);
		send_word(MODE_LOAD, 32'h5555_5555, 1'b0);
		send_word(MODE_LOAD, 32'hAAAA_AAAA, 1'b0);
		send_word(MODE_LOAD, -1, 1'b1);
		for (int k = 0; k < 9; k++)
			send_word(MODE_READ, $urandom, 1'b0);
		send_word(MODE_LOAD, 2, 1'b0);
		send_word(MODE_LOAD, 1, 1'b1);
		send_word(MODE_READ, '0, 1'b0);
		n_batches += 3;
		drain_pause();

		// store overflow: the dropped load still carries last, then the smallest values
		for (int k = 0; k < DEPTH + 3; k++)
			send_word(MODE_LOAD, rand_elem(), k == DEPTH + 2);
		for (int k = 0; k < OVF_READS; k++)
			send_word(MODE_READ, $urandom, 1'($urandom_range(1)));
		n_batches++;
		drain_pause();

		// random batches across the idle phases
		rand_base = n_loads + n_reads;
		while (n_loads + n_reads - rand_base < RAND_WORDS)
			random_batch();

		drain_pause();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d loads, %0d reads, %0d sorted batches incl. a %0d-deep overflow",
			n_loads, n_reads, n_batches, DEPTH);
		$display("%0d answers compared, %0d of them sorted values", checked, valued);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
hdl/cse_pkg.sv
hdl/cse_ram.sv
hdl/comb_sort_engine.sv
test/cse_sort_checker.sv
test/tb_comb_sort_engine.sv
